// File: src/i64alu_pkg.sv
`default_nettype none
package i64alu_pkg;

    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_SUB    = 5'd1,
        CMD_MUL    = 5'd2,
        CMD_DIV    = 5'd3,
        CMD_REM    = 5'd4,
        CMD_DIVMOD = 5'd5,
        CMD_POW    = 5'd6,
        CMD_NEG    = 5'd7,
        CMD_ABS    = 5'd8,
        CMD_NOT    = 5'd9,
        CMD_SHL    = 5'd10,
        CMD_SHR    = 5'd11,
        CMD_AND    = 5'd12,
        CMD_XOR    = 5'd13,
        CMD_OR     = 5'd14,
        CMD_CMP    = 5'd15,
        CMD_HASH   = 5'd16,
        CMD_NZ     = 5'd17
    } cmd_t;

    localparam logic [2:0] CMP_LT = 3'd0;
    localparam logic [2:0] CMP_LE = 3'd1;
    localparam logic [2:0] CMP_EQ = 3'd2;
    localparam logic [2:0] CMP_NE = 3'd3;
    localparam logic [2:0] CMP_GT = 3'd4;
    localparam logic [2:0] CMP_GE = 3'd5;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_SHIFT = 2'd2;
    localparam logic [1:0] ERR_EXP   = 2'd3;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

    // kind of multi-cycle work the datapath runs
    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_MUL  = 3'd1,
        OP_DIV  = 3'd2,
        OP_POW  = 3'd3,
        OP_HASH = 3'd4
    } op_t;

    typedef struct packed {
        logic load;   // capture the input beat
        logic step;   // advance one iteration
        logic mstart; // launch the shared multiplier
        logic finish; // form the final result
    } ctl_t;

    typedef struct packed {
        op_t  op;     // work class of the loaded item
        logic last;   // iteration count or exponent exhausted
        logic mdone;  // multiplier result ready
    } sts_t;

endpackage
`default_nettype wire

// File: src/i64alu_if.sv
`default_nettype none
interface i64alu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  command;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic [2:0]  compare_kind;
    modport source (output valid, command, operand_a, operand_b, compare_kind, input ready);
    modport sink (input valid, command, operand_a, operand_b, compare_kind, output ready);
endinterface

interface i64alu_out_if;
    logic        valid;
    logic        ready;
    logic signed [63:0] value;
    logic signed [63:0] second_value;
    logic [1:0]  error;
    modport source (output valid, value, second_value, error, input ready);
    modport sink (input valid, value, second_value, error, output ready);
endinterface
`default_nettype wire

// File: src/i64alu_mul.sv
`default_nettype none
// 64x64 wrapping multiply from three 32x32 partial products, one per cycle.
module i64alu_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    input  wire logic [63:0] y,
    output logic             done,
    output logic [63:0]      prod
);
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, y_reg, acc_reg, acc_next;
    logic [63:0] pp_reg, pp_next;
    logic [31:0] ma, mb;

    always_comb
    begin
        ma = 32'd0;
        mb = 32'd0;
        case (cnt_reg)
            3'd1: begin ma = x_reg[31:0];  mb = y_reg[31:0];  end
            3'd2: begin ma = x_reg[63:32]; mb = y_reg[31:0];  end
            3'd3: begin ma = x_reg[31:0];  mb = y_reg[63:32]; end
            default: begin ma = 32'd0; mb = 32'd0; end
        endcase
        pp_next = ma * mb;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        case (cnt_reg)
            3'd2: acc_next = pp_reg;
            3'd3: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
            3'd4: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
            default: acc_next = acc_reg;
        endcase
        if (start)
            cnt_next = 3'd1;
        else if (cnt_reg != 3'd0 && cnt_reg != 3'd5)
            cnt_next = cnt_reg + 3'd1;
        else
            cnt_next = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        pp_reg  <= pp_next;
        acc_reg <= acc_next;
    end

    assign done = (cnt_reg == 3'd5);
    assign prod = acc_reg;
endmodule
`default_nettype wire

// File: src/i64alu_dp.sv
`default_nettype none
module i64alu_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire i64alu_pkg::ctl_t  ctl,
    output i64alu_pkg::sts_t       sts,
    input  wire logic [4:0]        in_cmd,
    input  wire logic [63:0]       in_a,
    input  wire logic [63:0]       in_b,
    input  wire logic [2:0]        in_kind,
    output logic [63:0]            res_value,
    output logic [63:0]            res_second,
    output logic [1:0]             res_error
);
    logic [4:0]  cmd_reg;
    logic [63:0] a_reg, b_reg;
    logic [2:0]  kind_reg;
    i64alu_pkg::op_t op_reg, op_next;
    logic [6:0]  cnt_reg;
    // divider: partial remainder, quotient/dividend shift, magnitude divisor
    logic [63:0] rem_reg, quo_reg, dvs_reg;
    // power / hash state
    logic [63:0] acc_reg, base_reg, exp_reg;
    logic        phase_reg;
    logic [63:0] mx, my, mprod;
    logic        mdone;
    logic [64:0] trial;
    logic [64:0] rshift;
    logic [63:0] ma, mb, q_s, r_s, shamt;
    logic        lt, eq, cr, big;
    logic [63:0] v;
    logic [63:0] s;
    logic [1:0]  e;

    i64alu_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.mstart),
        .x     (mx),
        .y     (my),
        .done  (mdone),
        .prod  (mprod)
    );

    assign ma = in_a[63] ? (64'd0 - in_a) : in_a;
    assign mb = in_b[63] ? (64'd0 - in_b) : in_b;

    always_comb
    begin
        unique case (in_cmd) inside
            i64alu_pkg::CMD_MUL:
                op_next = i64alu_pkg::OP_MUL;
            i64alu_pkg::CMD_DIV, i64alu_pkg::CMD_REM, i64alu_pkg::CMD_DIVMOD:
                op_next = (in_b == 64'd0) ? i64alu_pkg::OP_NONE : i64alu_pkg::OP_DIV;
            i64alu_pkg::CMD_POW:
                op_next = in_b[63] ? i64alu_pkg::OP_NONE : i64alu_pkg::OP_POW;
            i64alu_pkg::CMD_HASH:
                op_next = i64alu_pkg::OP_HASH;
            default:
                op_next = i64alu_pkg::OP_NONE;
        endcase
    end

    // multiplier operands per work class and power phase
    always_comb
    begin
        case (op_reg)
            i64alu_pkg::OP_MUL:  begin mx = a_reg; my = b_reg; end
            i64alu_pkg::OP_HASH: begin mx = acc_reg ^ {56'd0, a_reg[7:0]};
                                       my = i64alu_pkg::FNV_PRIME; end
            default: begin
                mx = phase_reg ? base_reg : acc_reg;
                my = base_reg;
            end
        endcase
    end

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= i64alu_pkg::OP_NONE;
            cnt_reg   <= 7'd0;
            phase_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            op_reg    <= op_next;
            cnt_reg   <= 7'd0;
            phase_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            cnt_reg   <= cnt_reg + 7'd1;
            phase_reg <= ~phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= in_cmd;
            a_reg    <= in_a;
            b_reg    <= in_b;
            kind_reg <= in_kind;
            rem_reg  <= 64'd0;
            quo_reg  <= ma;
            dvs_reg  <= mb;
            base_reg <= in_a;
            exp_reg  <= in_b;
            acc_reg  <= (in_cmd == i64alu_pkg::CMD_HASH) ? i64alu_pkg::FNV_BASIS : 64'd1;
        end
        else if (ctl.step)
        begin
            case (op_reg)
                i64alu_pkg::OP_DIV:
                begin
                    // one restoring step per bit
                    if (!trial[64])
                    begin
                        rem_reg <= trial[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], quo_reg[63]};
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                end
                i64alu_pkg::OP_POW:
                begin
                    // even step: multiply acc if bit set; odd step: square base
                    if (!phase_reg)
                    begin
                        if (exp_reg[0])
                            acc_reg <= mprod;
                    end
                    else
                    begin
                        base_reg <= mprod;
                        exp_reg  <= {1'b0, exp_reg[63:1]};
                    end
                end
                i64alu_pkg::OP_HASH:
                begin
                    acc_reg <= mprod;
                    a_reg   <= {8'd0, a_reg[63:8]};
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    always_comb
    begin
        case (op_reg)
            i64alu_pkg::OP_DIV:  sts.last = (cnt_reg == 7'd63);
            i64alu_pkg::OP_POW:  sts.last = (exp_reg == 64'd0);
            // all eight bytes folded in
            i64alu_pkg::OP_HASH: sts.last = (cnt_reg == 7'd8);
            default:             sts.last = 1'b1;
        endcase
        sts.op    = op_reg;
        sts.mdone = mdone;
    end

    assign q_s = (a_reg[63] ^ b_reg[63]) ? (64'd0 - quo_reg) : quo_reg;
    assign r_s = a_reg[63] ? (64'd0 - rem_reg) : rem_reg;
    assign shamt = b_reg;
    assign big = (shamt[62:6] != 57'd0);
    assign rshift = $signed({a_reg[63], a_reg}) >>> shamt[5:0];
    assign lt = $signed(a_reg) < $signed(b_reg);
    assign eq = (a_reg == b_reg);

    always_comb
    begin
        v = 64'd0;
        s = 64'd0;
        e = i64alu_pkg::ERR_OK;
        cr = 1'b0;
        case (kind_reg)
            i64alu_pkg::CMP_LT: cr = lt;
            i64alu_pkg::CMP_LE: cr = lt | eq;
            i64alu_pkg::CMP_EQ: cr = eq;
            i64alu_pkg::CMP_NE: cr = ~eq;
            i64alu_pkg::CMP_GT: cr = ~lt & ~eq;
            i64alu_pkg::CMP_GE: cr = ~lt;
            default:            cr = 1'b0;
        endcase
        case (cmd_reg) inside
            i64alu_pkg::CMD_ADD: v = a_reg + b_reg;
            i64alu_pkg::CMD_SUB: v = a_reg - b_reg;
            i64alu_pkg::CMD_MUL: v = mprod;
            i64alu_pkg::CMD_DIV, i64alu_pkg::CMD_REM, i64alu_pkg::CMD_DIVMOD:
            begin
                if (b_reg == 64'd0)
                    e = i64alu_pkg::ERR_DIV0;
                else if (cmd_reg == i64alu_pkg::CMD_DIV)
                    v = q_s;
                else if (cmd_reg == i64alu_pkg::CMD_REM)
                    v = r_s;
                else
                begin
                    v = q_s;
                    s = r_s;
                end
            end
            i64alu_pkg::CMD_POW:
                if (b_reg[63]) e = i64alu_pkg::ERR_EXP;
                else v = acc_reg;
            i64alu_pkg::CMD_NEG: v = 64'd0 - a_reg;
            i64alu_pkg::CMD_ABS: v = a_reg[63] ? (64'd0 - a_reg) : a_reg;
            i64alu_pkg::CMD_NOT: v = ~a_reg;
            i64alu_pkg::CMD_SHL:
                if (shamt[63]) e = i64alu_pkg::ERR_SHIFT;
                else if (big) v = 64'd0;
                else v = a_reg << shamt[5:0];
            i64alu_pkg::CMD_SHR:
                if (shamt[63]) e = i64alu_pkg::ERR_SHIFT;
                else if (big) v = {64{a_reg[63]}};
                else v = rshift[63:0];
            i64alu_pkg::CMD_AND: v = a_reg & b_reg;
            i64alu_pkg::CMD_XOR: v = a_reg ^ b_reg;
            i64alu_pkg::CMD_OR:  v = a_reg | b_reg;
            i64alu_pkg::CMD_CMP: v = {63'd0, cr};
            i64alu_pkg::CMD_HASH: v = acc_reg;
            i64alu_pkg::CMD_NZ:  v = {63'd0, (a_reg != 64'd0)};
            default: v = 64'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            res_value  <= v;
            res_second <= s;
            res_error  <= e;
        end
    end
endmodule
`default_nettype wire

// File: src/i64alu_ctrl.sv
`default_nettype none
module i64alu_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output i64alu_pkg::ctl_t      ctl,
    input  wire i64alu_pkg::sts_t sts
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_MWAIT = 5'b00100,
        ST_DONE  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   needs_mul;

    // multiply-based work waits for the shared multiplier each step
    assign needs_mul = (sts.op == i64alu_pkg::OP_MUL) || (sts.op == i64alu_pkg::OP_POW)
                    || (sts.op == i64alu_pkg::OP_HASH);

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.op == i64alu_pkg::OP_MUL)
                begin
                    ctl.mstart = 1'b1;
                    state_next = ST_MWAIT;
                end
                else if (sts.op == i64alu_pkg::OP_DIV)
                begin
                    ctl.step = 1'b1;
                    if (sts.last)
                        state_next = ST_DONE;
                end
                else if (needs_mul && !sts.last)
                begin
                    ctl.mstart = 1'b1;
                    state_next = ST_MWAIT;
                end
                else
                    state_next = ST_DONE;
            end
            ST_MWAIT:
            begin
                if (sts.mdone)
                begin
                    if (sts.op == i64alu_pkg::OP_MUL)
                        state_next = ST_DONE;
                    else
                    begin
                        ctl.step = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_DONE:
            begin
                ctl.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("accept while result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> out_valid)
        else $error("result not presented after finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
endmodule
`default_nettype wire

// File: src/int64_alu_divide_power_hash.sv
`default_nettype none
// Work per item: simple commands finish without iterating; mul takes one multiplier
//   pass, div/rem/divmod one divider step per quotient bit, hash one multiplier pass
//   per byte, pow two multiplier passes per exponent bit. One item at a time; the
//   next beat is taken in the cycle after the result beat leaves. The radix-2
//   divider loop and the shared multiplier set the time taken per item.
// Reset: rst_n asynchronous active low; returns to idle, no result pending.
module int64_alu_divide_power_hash (
    input wire logic    clk,
    input wire logic    rst_n,
    i64alu_in_if.sink   in_ch,
    i64alu_out_if.source out_ch
);
    i64alu_pkg::ctl_t ctl;
    i64alu_pkg::sts_t sts;
    logic [63:0] rv, rs;
    logic [1:0]  re;

    // sequence load, iterate, finish, present
    i64alu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    // divider, power, hash and simple ops; result held in output registers
    i64alu_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .in_cmd     (in_ch.command),
        .in_a       (in_ch.operand_a),
        .in_b       (in_ch.operand_b),
        .in_kind    (in_ch.compare_kind),
        .res_value  (rv),
        .res_second (rs),
        .res_error  (re)
    );

    assign out_ch.value        = rv;
    assign out_ch.second_value = rs;
    assign out_ch.error        = re;
endmodule
`default_nettype wire
